@@ rtl/core/nand_command_sequencer_defines.svh @@
// Assertion macros shared by the NAND command sequencer RTL.
`ifndef NAND_COMMAND_SEQUENCER_DEFINES_SVH
`define NAND_COMMAND_SEQUENCER_DEFINES_SVH

`ifndef SYNTHESIS
// Check a property on every rising clock edge outside reset.
`define NSEQ_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("nseq: assertion failed");
// Check that an expression never holds outside reset.
`define NSEQ_ASSERT_NEVER(lbl, clk, rstn, expr) \
  `NSEQ_ASSERT(lbl, clk, rstn, !(expr))
`else
`define NSEQ_ASSERT(lbl, clk, rstn, prop)
`define NSEQ_ASSERT_NEVER(lbl, clk, rstn, expr)
`endif

`endif

@@ rtl/core/nseq_pkg.sv @@
// Types, codes and constants of the NAND command sequencer.
package nseq_pkg;

  // Row address width on the bus
  localparam int unsigned ROW_BITS = 24;
  localparam logic [23:0] ROW_MASK = 24'((64'd1 << ROW_BITS) - 64'd1);

  // Descriptor queue between front and back
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  // Configuration register indexes
  localparam logic [3:0] CFG_PAGE_LIMIT      = 4'd0;
  localparam logic [3:0] CFG_PAGES_PER_BLOCK = 4'd1;

  localparam logic [24:0] PAGE_LIMIT_RST      = 25'd65536;
  localparam logic [8:0]  PAGES_PER_BLOCK_RST = 9'd64;

  // NAND command bytes
  localparam logic [7:0] CMD_READ_1ST  = 8'h00;
  localparam logic [7:0] CMD_READ_2ND  = 8'h30;
  localparam logic [7:0] CMD_PROG_1ST  = 8'h80;
  localparam logic [7:0] CMD_PROG_2ND  = 8'h10;
  localparam logic [7:0] CMD_ERASE_1ST = 8'h60;
  localparam logic [7:0] CMD_ERASE_2ND = 8'hD0;
  localparam logic [7:0] CMD_STATUS    = 8'h70;
  localparam logic [7:0] CMD_READ_ID   = 8'h90;
  localparam logic [7:0] CMD_CB_READ   = 8'h35;
  localparam logic [7:0] CMD_CB_PROG   = 8'h85;
  localparam logic [7:0] ID_ADDR       = 8'h00;

  typedef enum logic [3:0] {
    OP_READ          = 4'd0,
    OP_PROG_START    = 4'd1,
    OP_DATA_WRITE    = 4'd2,
    OP_DATA_READ     = 4'd3,
    OP_ERASE         = 4'd4,
    OP_STATUS        = 4'd5,
    OP_READ_ID       = 4'd6,
    OP_COPYBACK      = 4'd7,
    OP_COPYBACK_OPEN = 4'd8
  } op_e;

  typedef enum logic [2:0] {
    KIND_CMD  = 3'd0,
    KIND_ADDR = 3'd1,
    KIND_WR   = 3'd2,
    KIND_RD   = 3'd3,
    KIND_ERR  = 3'd4
  } kind_e;

  typedef struct packed {
    logic [3:0]  opcode;
    logic [23:0] page;
    logic [23:0] dest_page;
    logic [11:0] column;
    logic [7:0]  data_byte;
    logic        last_data;
  } in_t;

  typedef struct packed {
    logic [2:0] cycle_kind;
    logic [7:0] bus_byte;
    logic       last;
  } out_t;

  typedef struct packed {
    logic [24:0] page_limit;
    logic [8:0]  pages_per_block;
  } cfg_t;

  // Classified request handed from front to back
  typedef struct packed {
    op_e         op;
    logic        err;
    logic [23:0] page;
    logic [23:0] dest_page;
    logic [11:0] column;
    logic [7:0]  data_byte;
    logic        last_data;
    logic [23:0] erase_row;
  } desc_t;

endpackage

@@ rtl/core/nseq_front.sv @@
// Front end: accepts requests, forms the erase row and checks page range.
module nseq_front import nseq_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  cfg_t  cfg_i,
  input  logic  push,
  output logic  full,
  input  in_t   req_i,
  output logic  q_push_o,
  input  logic  q_full_i,
  output desc_t q_desc_o
);

  logic        stg_valid_q, stg_valid_d;
  in_t         stg_q;
  logic [32:0] prod_q;
  logic        accept;
  logic        used;
  logic        advance;
  logic        page_ok, dest_ok, row_ok;

  assign accept = push && !full;

  // Classify the staged request
  always_comb begin
    page_ok = {1'b0, stg_q.page} < cfg_i.page_limit;
    dest_ok = {1'b0, stg_q.dest_page} < cfg_i.page_limit;
    row_ok  = prod_q < {8'd0, cfg_i.page_limit};
    used    = 1'b1;
    q_desc_o.err = 1'b0;
    case (stg_q.opcode)
      OP_READ, OP_PROG_START:        q_desc_o.err = !page_ok;
      OP_ERASE:                      q_desc_o.err = !row_ok;
      OP_COPYBACK, OP_COPYBACK_OPEN: q_desc_o.err = !(page_ok && dest_ok);
      OP_DATA_WRITE, OP_DATA_READ, OP_STATUS, OP_READ_ID: q_desc_o.err = 1'b0;
      default:                       used = 1'b0;
    endcase
    q_desc_o.op        = op_e'(stg_q.opcode);
    q_desc_o.page      = stg_q.page;
    q_desc_o.dest_page = stg_q.dest_page;
    q_desc_o.column    = stg_q.column;
    q_desc_o.data_byte = stg_q.data_byte;
    q_desc_o.last_data = stg_q.last_data;
    q_desc_o.erase_row = prod_q[23:0] & ROW_MASK;
  end

  // Drop unused opcodes, otherwise move into the queue when it has room
  assign advance  = stg_valid_q && (!used || !q_full_i);
  assign q_push_o = stg_valid_q && used && !q_full_i;
  assign full     = stg_valid_q && !advance;

  always_comb begin
    stg_valid_d = stg_valid_q;
    if (accept) begin
      stg_valid_d = 1'b1;
    end else if (advance) begin
      stg_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_valid_q <= 1'b0;
    end else begin
      stg_valid_q <= stg_valid_d;
    end
  end

  // Capture the request and the block-to-row product
  always_ff @(posedge clk_i) begin
    if (accept) begin
      stg_q  <= req_i;
      prod_q <= req_i.page * cfg_i.pages_per_block;
    end
  end

endmodule

@@ rtl/core/nseq_fifo.sv @@
// Short descriptor queue between front and back.
`include "nand_command_sequencer_defines.svh"
module nseq_fifo import nseq_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  desc_t push_desc_i,
  output logic  full_o,
  input  logic  pop_i,
  output desc_t head_o,
  output logic  empty_o
);

  desc_t             mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] count_q;

  assign full_o  = count_q == QCNT_W'(QDEPTH);
  assign empty_o = count_q == '0;
  assign head_o  = mem_q[rd_ptr_q];

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  // Store the pushed descriptor
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_desc_i;
    end
  end

  `NSEQ_ASSERT_NEVER(a_no_push_full, clk_i, rst_ni, push_i && full_o)
  `NSEQ_ASSERT_NEVER(a_no_pop_empty, clk_i, rst_ni, pop_i && empty_o)

endmodule

@@ rtl/core/nseq_back.sv @@
// Back end: steps through the bus cycles of each queued request.
`include "nand_command_sequencer_defines.svh"
module nseq_back import nseq_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  desc_t head_i,
  input  logic  head_empty_i,
  output logic  head_pop_o,
  output logic  empty,
  input  logic  pop,
  output out_t  rsp_o
);

  logic [3:0] step_q, step_d;
  logic       out_valid_q, out_valid_d;
  out_t       out_q;
  out_t       cur;
  logic [3:0] seq_len;
  logic       is_last;
  logic       emit;

  // Pick one address byte: column low, column high, row low, mid, high
  function automatic logic [7:0] addr_byte(logic [23:0] row, logic [11:0] col,
                                           logic [2:0] idx);
    logic [23:0] r;
    logic [7:0]  b;
    r = row & ROW_MASK;
    case (idx)
      3'd0:    b = col[7:0];
      3'd1:    b = {4'h0, col[11:8]};
      3'd2:    b = r[7:0];
      3'd3:    b = r[15:8];
      default: b = r[23:16];
    endcase
    return b;
  endfunction

  // Number of bus cycles of a request
  function automatic logic [3:0] len_of(desc_t d);
    logic [3:0] n;
    case (d.op)
      OP_READ:          n = 4'd7;
      OP_PROG_START:    n = 4'd6;
      OP_DATA_WRITE:    n = d.last_data ? 4'd2 : 4'd1;
      OP_DATA_READ:     n = 4'd1;
      OP_ERASE:         n = 4'd5;
      OP_STATUS:        n = 4'd2;
      OP_READ_ID:       n = 4'd6;
      OP_COPYBACK:      n = 4'd14;
      OP_COPYBACK_OPEN: n = 4'd13;
      default:          n = 4'd1;
    endcase
    if (d.err) begin
      n = 4'd1;
    end
    return n;
  endfunction

  // Bus cycle at a given step of a request
  function automatic out_t cycle_of(desc_t d, logic [3:0] s);
    out_t o;
    o.cycle_kind = KIND_RD;
    o.bus_byte   = 8'h00;
    o.last       = 1'b0;
    case (d.op)
      OP_READ: begin
        if (s == 4'd0) begin
          o.cycle_kind = KIND_CMD; o.bus_byte = CMD_READ_1ST;
        end else if (s == 4'd6) begin
          o.cycle_kind = KIND_CMD; o.bus_byte = CMD_READ_2ND;
        end else begin
          o.cycle_kind = KIND_ADDR;
          o.bus_byte   = addr_byte(d.page, d.column, 3'(s - 4'd1));
        end
      end
      OP_PROG_START: begin
        if (s == 4'd0) begin
          o.cycle_kind = KIND_CMD; o.bus_byte = CMD_PROG_1ST;
        end else begin
          o.cycle_kind = KIND_ADDR;
          o.bus_byte   = addr_byte(d.page, d.column, 3'(s - 4'd1));
        end
      end
      OP_DATA_WRITE: begin
        if (s == 4'd0) begin
          o.cycle_kind = KIND_WR; o.bus_byte = d.data_byte;
        end else begin
          o.cycle_kind = KIND_CMD; o.bus_byte = CMD_PROG_2ND;
        end
      end
      OP_ERASE: begin
        if (s == 4'd0) begin
          o.cycle_kind = KIND_CMD; o.bus_byte = CMD_ERASE_1ST;
        end else if (s == 4'd4) begin
          o.cycle_kind = KIND_CMD; o.bus_byte = CMD_ERASE_2ND;
        end else begin
          o.cycle_kind = KIND_ADDR;
          o.bus_byte   = addr_byte(d.erase_row, 12'd0, 3'(s + 4'd1));
        end
      end
      OP_STATUS: begin
        if (s == 4'd0) begin
          o.cycle_kind = KIND_CMD; o.bus_byte = CMD_STATUS;
        end
      end
      OP_READ_ID: begin
        if (s == 4'd0) begin
          o.cycle_kind = KIND_CMD; o.bus_byte = CMD_READ_ID;
        end else if (s == 4'd1) begin
          o.cycle_kind = KIND_ADDR; o.bus_byte = ID_ADDR;
        end
      end
      OP_COPYBACK, OP_COPYBACK_OPEN: begin
        if (s == 4'd0) begin
          o.cycle_kind = KIND_CMD; o.bus_byte = CMD_READ_1ST;
        end else if (s <= 4'd5) begin
          o.cycle_kind = KIND_ADDR;
          o.bus_byte   = addr_byte(d.page, 12'd0, 3'(s - 4'd1));
        end else if (s == 4'd6) begin
          o.cycle_kind = KIND_CMD; o.bus_byte = CMD_CB_READ;
        end else if (s == 4'd7) begin
          o.cycle_kind = KIND_CMD; o.bus_byte = CMD_CB_PROG;
        end else if (s <= 4'd12) begin
          o.cycle_kind = KIND_ADDR;
          o.bus_byte   = addr_byte(d.dest_page, 12'd0, 3'(s - 4'd8));
        end else begin
          o.cycle_kind = KIND_CMD; o.bus_byte = CMD_PROG_2ND;
        end
      end
      default: begin
        o.cycle_kind = KIND_RD;
      end
    endcase
    if (d.err) begin
      o.cycle_kind = KIND_ERR;
      o.bus_byte   = 8'h00;
    end
    return o;
  endfunction

  assign seq_len    = len_of(head_i);
  assign is_last    = step_q == seq_len - 4'd1;
  assign emit       = !head_empty_i && (!out_valid_q || pop);
  assign head_pop_o = emit && is_last;
  assign empty      = !out_valid_q;
  assign rsp_o      = out_q;

  // Form the current bus cycle
  always_comb begin
    cur      = cycle_of(head_i, step_q);
    cur.last = is_last;
  end

  // Advance the step and the output register
  always_comb begin
    step_d      = step_q;
    out_valid_d = out_valid_q;
    if (emit) begin
      step_d      = is_last ? 4'd0 : step_q + 4'd1;
      out_valid_d = 1'b1;
    end else if (pop) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= 4'd0;
      out_valid_q <= 1'b0;
    end else begin
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q <= cur;
    end
  end

  `NSEQ_ASSERT_NEVER(a_step_in_range, clk_i, rst_ni, !head_empty_i && step_q >= seq_len)
  `NSEQ_ASSERT_NEVER(a_step_idle_zero, clk_i, rst_ni, head_empty_i && step_q != 4'd0)

endmodule

@@ rtl/core/nand_command_sequencer.sv @@
// Top level of the NAND command sequencer.
//
//   channel   direction  handshake         payload
//   request   in         push / full       req_i  (in_t)
//   bus cycle out        empty / pop       rsp_o  (out_t)
//   config    in         cfg_we_i          cfg_idx_i, cfg_wdata_i
//
// A request enters through the front stage; the back end sends one bus cycle
// per clock while the queue holds a request and pop keeps the output free, and
// a request has 1 to 14 bus cycles, set by the step counter of the back end.
// The first bus cycle passes the front stage, the queue and the output register.
// Reset empties the stage, queue and output register and sets page_limit to
// 65536 and pages_per_block to 64. Pop low holds the output; the back end
// then stops, the queue fills and full rises.
module nand_command_sequencer import nseq_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  in_t         req_i,
  output logic        empty,
  input  logic        pop,
  output out_t        rsp_o,
  input  logic        cfg_we_i,
  input  logic [3:0]  cfg_idx_i,
  input  logic [24:0] cfg_wdata_i
);

  cfg_t  cfg_q;
  desc_t q_in, q_head;
  logic  q_push, q_full, q_pop, q_empty;

  // Hold configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.page_limit      <= PAGE_LIMIT_RST;
      cfg_q.pages_per_block <= PAGES_PER_BLOCK_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_PAGE_LIMIT:      cfg_q.page_limit      <= cfg_wdata_i;
        CFG_PAGES_PER_BLOCK: cfg_q.pages_per_block <= cfg_wdata_i[8:0];
        default:             cfg_q                 <= cfg_q;
      endcase
    end
  end

  nseq_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .push     (push),
    .full     (full),
    .req_i    (req_i),
    .q_push_o (q_push),
    .q_full_i (q_full),
    .q_desc_o (q_in)
  );

  nseq_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_desc_i (q_in),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .head_o      (q_head),
    .empty_o     (q_empty)
  );

  nseq_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (q_head),
    .head_empty_i (q_empty),
    .head_pop_o   (q_pop),
    .empty        (empty),
    .pop          (pop),
    .rsp_o        (rsp_o)
  );

endmodule

@@ sim/nseq_checker.sv @@
// Bus cycle predictor and checker for the NAND command sequencer.
`timescale 1ns / 1ps

module nseq_checker import nseq_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  logic        full_i,
  input  in_t         req_i,
  input  logic        empty_i,
  input  logic        pop_i,
  input  out_t        rsp_i,
  input  logic        cfg_we_i,
  input  logic [3:0]  cfg_idx_i,
  input  logic [24:0] cfg_wdata_i,
  output int unsigned fail_cnt_o,
  output int unsigned pending_o,
  output int unsigned checked_o
);

  localparam int unsigned PRINT_CAP = 200;

  logic [24:0] page_limit_q;
  logic [8:0]  pages_per_block_q;
  out_t        bus_cycles_q[$];

  initial begin
    fail_cnt_o = 0;
    pending_o  = 0;
    checked_o  = 0;
  end

  // Count a failure and print one line for it
  task automatic report_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
    fail_cnt_o++;
    if (fail_cnt_o <= PRINT_CAP) begin
      $display("[%0t] nseq: %s: expected 0x%0h, got 0x%0h", $time, what, want, got);
    end
  endtask

  task automatic add_cycle(input kind_e kind, input logic [7:0] bus_byte);
    out_t c;
    c.cycle_kind = kind;
    c.bus_byte   = bus_byte;
    c.last       = 1'b0;
    bus_cycles_q.push_back(c);
  endtask

  task automatic add_row(input logic [23:0] row);
    add_cycle(KIND_ADDR, row[7:0]);
    add_cycle(KIND_ADDR, row[15:8]);
    add_cycle(KIND_ADDR, row[23:16]);
  endtask

  // Column low and high byte, then the three row bytes
  task automatic add_address(input logic [23:0] row, input logic [11:0] col);
    add_cycle(KIND_ADDR, col[7:0]);
    add_cycle(KIND_ADDR, {4'h0, col[11:8]});
    add_row(row);
  endtask

  // Append the bus cycles one request produces under the current settings
  task automatic predict_bus_cycles(input in_t r);
    longint unsigned erase_row;
    longint unsigned limit;
    bit          in_range;
    int unsigned first;
    first     = bus_cycles_q.size();
    limit     = 64'(page_limit_q);
    erase_row = 64'(r.page) * 64'(pages_per_block_q);
    in_range  = 1'b1;

    // Range check on every page or row the request puts on the bus
    case (r.opcode)
      OP_READ, OP_PROG_START: in_range = 64'(r.page) < limit;
      OP_ERASE:               in_range = erase_row < limit;
      OP_COPYBACK, OP_COPYBACK_OPEN:
        in_range = (64'(r.page) < limit) && (64'(r.dest_page) < limit);
      default: ;
    endcase

    if (!in_range) begin
      add_cycle(KIND_ERR, 8'h00);
    end else begin
      case (r.opcode)
        OP_READ: begin
          add_cycle(KIND_CMD, CMD_READ_1ST);
          add_address(r.page, r.column);
          add_cycle(KIND_CMD, CMD_READ_2ND);
        end
        OP_PROG_START: begin
          add_cycle(KIND_CMD, CMD_PROG_1ST);
          add_address(r.page, r.column);
        end
        OP_DATA_WRITE: begin
          add_cycle(KIND_WR, r.data_byte);
          if (r.last_data) add_cycle(KIND_CMD, CMD_PROG_2ND);
        end
        OP_DATA_READ: add_cycle(KIND_RD, 8'h00);
        OP_ERASE: begin
          add_cycle(KIND_CMD, CMD_ERASE_1ST);
          add_row(erase_row[23:0]);
          add_cycle(KIND_CMD, CMD_ERASE_2ND);
        end
        OP_STATUS: begin
          add_cycle(KIND_CMD, CMD_STATUS);
          add_cycle(KIND_RD, 8'h00);
        end
        OP_READ_ID: begin
          add_cycle(KIND_CMD, CMD_READ_ID);
          add_cycle(KIND_ADDR, ID_ADDR);
          repeat (4) add_cycle(KIND_RD, 8'h00);
        end
        OP_COPYBACK, OP_COPYBACK_OPEN: begin
          add_cycle(KIND_CMD, CMD_READ_1ST);
          add_address(r.page, 12'h000);
          add_cycle(KIND_CMD, CMD_CB_READ);
          add_cycle(KIND_CMD, CMD_CB_PROG);
          add_address(r.dest_page, 12'h000);
          if (r.opcode == OP_COPYBACK) add_cycle(KIND_CMD, CMD_PROG_2ND);
        end
        default: ;
      endcase
    end

    // Flag the final cycle of the request
    if (bus_cycles_q.size() > first) bus_cycles_q[bus_cycles_q.size() - 1].last = 1'b1;
  endtask

  // Track register writes, predict on accepted requests, compare popped cycles
  always @(posedge clk_i or negedge rst_ni) begin : watch
    out_t want;
    if (!rst_ni) begin
      page_limit_q      = PAGE_LIMIT_RST;
      pages_per_block_q = PAGES_PER_BLOCK_RST;
      bus_cycles_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_PAGE_LIMIT:      page_limit_q = cfg_wdata_i;
          CFG_PAGES_PER_BLOCK: pages_per_block_q = cfg_wdata_i[8:0];
          default: ;
        endcase
      end
      if (push_i && !full_i) predict_bus_cycles(req_i);
      if (pop_i && !empty_i) begin
        checked_o++;
        if (bus_cycles_q.size() == 0) begin
          report_mismatch("bus cycle with nothing expected", 0, 32'(rsp_i));
        end else begin
          want = bus_cycles_q.pop_front();
          if (rsp_i.cycle_kind !== want.cycle_kind)
            report_mismatch("cycle_kind", 32'(want.cycle_kind), 32'(rsp_i.cycle_kind));
          if (rsp_i.bus_byte !== want.bus_byte)
            report_mismatch("bus_byte", 32'(want.bus_byte), 32'(rsp_i.bus_byte));
          if (rsp_i.last !== want.last)
            report_mismatch("last", 32'(want.last), 32'(rsp_i.last));
        end
      end
    end
    pending_o = bus_cycles_q.size();
  end

endmodule

@@ sim/tb_top.sv @@
// Testbench top for the NAND command sequencer: stimulus, pacing and verdict.
`timescale 1ns / 1ps

module tb_top;
  import nseq_pkg::*;

  localparam int unsigned RESET_CYCLES = 8;
  localparam int unsigned DRAIN_CYCLES = 48;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned LIMIT_CYCLES = 400000;
  localparam int unsigned NUM_PHASES   = 8;
  localparam int unsigned PHASE_ITEMS  = 60;
  localparam logic [3:0]  CFG_SPARE_IDX = 4'd7;   // unmapped register index
  localparam logic [3:0]  OP_UNUSED_LO  = 4'd9;
  localparam logic [3:0]  OP_UNUSED_HI  = 4'd15;
  localparam longint unsigned PAGE_SPACE = 64'd1 << 24;

  typedef enum int unsigned {
    PACE_NONE,
    PACE_SEND_IDLE,
    PACE_RECV_STALL,
    PACE_BOTH
  } pace_e;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic        full;
  in_t         req = '0;
  logic        empty;
  logic        pop = 1'b0;
  out_t        rsp;
  logic        cfg_we_i = 1'b0;
  logic [3:0]  cfg_idx_i = '0;
  logic [24:0] cfg_wdata_i = '0;

  int unsigned fail_cnt;
  int unsigned pending;
  int unsigned checked;
  int unsigned sent_cnt = 0;
  int unsigned cycle_cnt = 0;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned hold_left = 0;
  logic        hold_kick = 1'b0;

  nand_command_sequencer i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .req_i       (req),
    .empty       (empty),
    .pop         (pop),
    .rsp_o       (rsp),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  nseq_checker i_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_i      (full),
    .req_i       (req),
    .empty_i     (empty),
    .pop_i       (pop),
    .rsp_i       (rsp),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .fail_cnt_o  (fail_cnt),
    .pending_o   (pending),
    .checked_o   (checked)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LIMIT_CYCLES) begin
      $display("[%0t] nseq: run exceeded %0d cycles", $time, LIMIT_CYCLES);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Drive pop: long hold on request, otherwise random stalls
  always @(posedge clk_i) begin
    if (hold_kick && hold_left == 0) begin
      hold_left <= HOLD_CYCLES;
      pop <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  function automatic in_t mk_req(input logic [3:0] op, input logic [23:0] pg,
                                 input logic [23:0] dst, input logic [11:0] col,
                                 input logic [7:0] dbyte, input logic ldata);
    in_t r;
    r.opcode    = op;
    r.page      = pg;
    r.dest_page = dst;
    r.column    = col;
    r.data_byte = dbyte;
    r.last_data = ldata;
    return r;
  endfunction

  // Mostly in range, some right at the limit, the rest anywhere
  function automatic logic [23:0] pick_page(input longint unsigned lim);
    int unsigned roll;
    longint unsigned span;
    roll = $urandom_range(0, 99);
    span = (lim > PAGE_SPACE) ? PAGE_SPACE : lim;
    if (lim == 0 || roll >= 85) return 24'($urandom);
    if (roll < 75) return 24'($urandom_range(0, 32'(span - 1)));
    return 24'(lim - 1 + $urandom_range(0, 2));
  endfunction

  function automatic in_t random_request(input longint unsigned lim,
                                         input int unsigned ppb);
    in_t r;
    longint unsigned top_block;
    if ($urandom_range(0, 99) < 94) r.opcode = 4'($urandom_range(0, 8));
    else r.opcode = 4'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
    r.page      = pick_page(lim);
    r.dest_page = pick_page(lim);
    r.column    = 12'($urandom);
    r.data_byte = 8'($urandom);
    r.last_data = 1'($urandom);
    // Keep most erases inside the array
    if (r.opcode == OP_ERASE && ppb != 0 && lim != 0 && $urandom_range(0, 99) < 75) begin
      top_block = (lim - 1) / ppb;
      if (top_block >= PAGE_SPACE) top_block = PAGE_SPACE - 1;
      r.page = 24'($urandom_range(0, 32'(top_block)));
    end
    return r;
  endfunction

  task automatic set_pacing(input pace_e mode);
    case (mode)
      PACE_SEND_IDLE:  begin send_idle_pct = 72; stall_pct <= 0;  end
      PACE_RECV_STALL: begin send_idle_pct = 0;  stall_pct <= 72; end
      PACE_BOTH:       begin send_idle_pct = 32; stall_pct <= 32; end
      default:         begin send_idle_pct = 0;  stall_pct <= 0;  end
    endcase
  endtask

  // Offer one request after a random gap and hold it until accepted
  task automatic send_req(input in_t r);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push <= 1'b1;
    req  <= r;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    sent_cnt++;
  endtask

  // Stop offering, wait for every expected cycle, then let the block settle
  task automatic drain();
    push <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Write both registers and poke the unmapped index
  task automatic write_cfg(input logic [24:0] lim, input logic [8:0] ppb);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_PAGE_LIMIT;
    cfg_wdata_i <= lim;
    @(posedge clk_i);
    cfg_idx_i   <= CFG_PAGES_PER_BLOCK;
    cfg_wdata_i <= {16'h0000, ppb};
    @(posedge clk_i);
    cfg_idx_i   <= CFG_SPARE_IDX;
    cfg_wdata_i <= 25'($urandom);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  longint unsigned lim_set[NUM_PHASES];
  int unsigned     ppb_set[NUM_PHASES];

  initial begin : stimulus
    int unsigned ph;
    int unsigned n;
    rst_ni = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    set_pacing(PACE_NONE);

    // Every operation and the range edges under the reset settings
    send_req(mk_req(OP_READ, 24'h000000, 24'h000000, 12'h000, 8'h00, 1'b0));
    send_req(mk_req(OP_READ, 24'h00FFFF, 24'hFFFFFF, 12'hFFF, 8'hFF, 1'b1));
    send_req(mk_req(OP_READ, 24'h010000, 24'h000000, 12'h123, 8'h00, 1'b0));
    send_req(mk_req(OP_PROG_START, 24'h00FFFF, 24'h000000, 12'hA5C, 8'h00, 1'b0));
    send_req(mk_req(OP_PROG_START, 24'hFFFFFF, 24'h000000, 12'h000, 8'h00, 1'b0));
    send_req(mk_req(OP_DATA_WRITE, 24'hFFFFFF, 24'hFFFFFF, 12'hFFF, 8'h00, 1'b0));
    send_req(mk_req(OP_DATA_WRITE, 24'h000000, 24'h000000, 12'h000, 8'hFF, 1'b1));
    send_req(mk_req(OP_DATA_READ, 24'hFFFFFF, 24'h000000, 12'h000, 8'h5A, 1'b1));
    send_req(mk_req(OP_ERASE, 24'd1023, 24'h000000, 12'h000, 8'h00, 1'b0));
    send_req(mk_req(OP_ERASE, 24'd1024, 24'h000000, 12'h000, 8'h00, 1'b0));
    send_req(mk_req(OP_STATUS, 24'h000000, 24'h000000, 12'h000, 8'h00, 1'b0));
    send_req(mk_req(OP_READ_ID, 24'hFFFFFF, 24'hFFFFFF, 12'hFFF, 8'hFF, 1'b1));
    send_req(mk_req(OP_COPYBACK, 24'h000001, 24'h00FFFF, 12'hFFF, 8'h00, 1'b0));
    send_req(mk_req(OP_COPYBACK, 24'h000001, 24'h010000, 12'h000, 8'h00, 1'b0));
    send_req(mk_req(OP_COPYBACK_OPEN, 24'h005A5A, 24'h001234, 12'h000, 8'h00, 1'b0));
    send_req(mk_req(OP_UNUSED_LO, 24'hFFFFFF, 24'hFFFFFF, 12'hFFF, 8'hFF, 1'b1));
    send_req(mk_req(OP_UNUSED_HI, 24'h000000, 24'h000000, 12'h000, 8'h00, 1'b0));

    // Zero page limit rejects every checked request
    drain();
    write_cfg(25'd0, 9'd0);
    send_req(mk_req(OP_READ, 24'h000000, 24'h000000, 12'h000, 8'h00, 1'b0));
    send_req(mk_req(OP_DATA_WRITE, 24'h000000, 24'h000000, 12'h000, 8'hC3, 1'b1));

    // Zero pages per block folds every erase onto row 0
    drain();
    write_cfg(25'd16777216, 9'd0);
    send_req(mk_req(OP_ERASE, 24'hFFFFFF, 24'h000000, 12'h000, 8'h00, 1'b0));
    send_req(mk_req(OP_READ, 24'hFFFFFF, 24'h000000, 12'hFFF, 8'h00, 1'b0));

    // Full-width erase row, in and out of range
    drain();
    write_cfg(25'd16777216, 9'd256);
    send_req(mk_req(OP_ERASE, 24'h00FFFF, 24'h000000, 12'h000, 8'h00, 1'b0));
    send_req(mk_req(OP_ERASE, 24'hFFFFFF, 24'h000000, 12'h000, 8'h00, 1'b0));
    send_req(mk_req(OP_COPYBACK_OPEN, 24'hFFFFFF, 24'hFFFFFF, 12'h000, 8'h00, 1'b0));

    // Erase row beyond 24 bits but under the limit goes out truncated
    drain();
    write_cfg(25'h1FFFFFF, 9'h1FF);
    send_req(mk_req(OP_ERASE, 24'h010000, 24'h000000, 12'h000, 8'h00, 1'b0));

    // Random phases over several settings and pacing modes
    lim_set = '{64'd65536, 64'd16777216, 64'd1, 64'h1FFFFFF,
                64'($urandom_range(1, 32'd16777216)), 64'd4096,
                64'($urandom_range(1, 32'd16777216)), 64'd256};
    ppb_set = '{64, 256, 1, 511, $urandom_range(1, 256), 0,
                $urandom_range(1, 256), 16};
    for (ph = 0; ph < NUM_PHASES; ph++) begin
      drain();
      write_cfg(25'(lim_set[ph]), 9'(ppb_set[ph]));
      set_pacing(pace_e'(ph % 4));
      if (ph == 4) begin
        hold_kick <= 1'b1;
        @(posedge clk_i);
        hold_kick <= 1'b0;
      end
      for (n = 0; n < PHASE_ITEMS; n++) begin
        // Pause the sender until the block has emptied
        if (ph == 6 && n == PHASE_ITEMS / 2) drain();
        send_req(random_request(lim_set[ph], ppb_set[ph]));
      end
    end

    drain();
    $display("nseq: %0d requests sent over %0d register settings and four pacing modes,",
             sent_cnt, NUM_PHASES + 5);
    $display("nseq: %0d bus cycles compared, including a long output hold.", checked);
    if (pending != 0) begin
      $display("nseq: %0d expected bus cycles never arrived", pending);
    end
    if (fail_cnt == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/nseq_pkg.sv
rtl/core/nseq_front.sv
rtl/core/nseq_fifo.sv
rtl/core/nseq_back.sv
rtl/core/nand_command_sequencer.sv
sim/nseq_checker.sv
sim/tb_top.sv
